// File: rtl/hsdv_pkg.sv
// ----------------------------------------------------------------------------
// hsdv_pkg
// shared constants, types and helpers of the hall sector / velocity decoder
// ----------------------------------------------------------------------------
package hsdv_pkg;

   localparam int TIME_BITS     = 32;
   localparam int VEL_FRAC_BITS = 8;
   localparam int VEL_BITS      = 32;
   localparam int CODE_BITS     = 3;
   localparam int ENTRY_BITS    = 4;
   localparam int SECTOR_BITS   = 3;
   localparam int NUM_SECTORS   = 6;

   // pi/3 * 1e6 in q.16
   localparam logic [63:0] K_Q16 = 64'd68629138715;

   // dividend width covers the widest velocity constant (16 fraction bits)
   localparam int DIV_BITS = 40;
   localparam int CNT_BITS = $clog2(DIV_BITS);

   localparam logic [VEL_BITS-2:0] VEL_MAX = {(VEL_BITS-1){1'b1}};

   localparam logic [31:0] SECTOR_MAP_RESET = 32'hF354120F;

   // register map, index taken from the word address
   localparam int  ADDR_BITS      = 3;
   localparam logic REG_SECTOR_MAP = 1'b0;

   // velocity constant rounded half up to VEL_FRAC_BITS fraction bits
   function automatic logic [DIV_BITS-1:0] vel_const();
      logic [63:0] k;
      int          sh;
      sh = 16 - VEL_FRAC_BITS;
      if (sh <= 0) begin
         k = K_Q16;
      end else begin
         k = (K_Q16 + (64'd1 << (sh - 1))) >> sh;
      end
      return k[DIV_BITS-1:0];
   endfunction

   localparam logic [DIV_BITS-1:0] VEL_CONST = vel_const();

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic step;
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage

// File: rtl/hsdv_ctrl.sv
// ----------------------------------------------------------------------------
// hsdv_ctrl
// sequencer: accept word, evaluate, run divider on a step, commit, present result
// ----------------------------------------------------------------------------
module hsdv_ctrl
   import hsdv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.step) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_BITS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/hsdv_dp.sv
// ----------------------------------------------------------------------------
// hsdv_dp
// sector lookup, rotor state, direction and restoring divider for velocity
// ----------------------------------------------------------------------------
module hsdv_dp
   import hsdv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [31:0]            sector_map,
   input  logic                   req_hall_a,
   input  logic                   req_hall_b,
   input  logic                   req_hall_c,
   input  logic [TIME_BITS-1:0]   req_time_us,
   output logic [CODE_BITS-1:0]   rsp_sample_code,
   output logic [SECTOR_BITS-1:0] rsp_sector,
   output logic                   rsp_dir_ccw,
   output logic signed [VEL_BITS-1:0] rsp_velocity,
   output logic                   rsp_stepped,
   output logic                   rsp_code_invalid
);

   // sample capture
   logic [CODE_BITS-1:0]   code_in;
   logic [ENTRY_BITS-1:0]  entry_in;
   logic                   invalid_in;
   logic [CODE_BITS-1:0]   code_ff;
   logic [SECTOR_BITS-1:0] entry_ff;
   logic                   invalid_ff;
   logic                   step_ff;
   logic                   first_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // rotor state
   logic [SECTOR_BITS-1:0] sector_ff;
   logic                   known_ff;
   logic                   ccw_ff;
   logic [VEL_BITS-1:0]    vel_ff;
   logic [TIME_BITS-1:0]   last_ff;
   logic                   stepped_ff;

   // divider
   logic [TIME_BITS-1:0]   dt_ff;
   logic [TIME_BITS-1:0]   rem_ff;
   logic [DIV_BITS-1:0]    quot_ff;
   logic [TIME_BITS:0]     rem_shift;
   logic [TIME_BITS:0]     rem_trial;
   logic                   fits;

   logic signed [SECTOR_BITS:0] diff;
   logic                   ccw_in;
   logic [VEL_BITS-2:0]    mag;
   logic [VEL_BITS-1:0]    vel_in;

   assign code_in    = {req_hall_a, req_hall_b, req_hall_c};
   assign entry_in   = sector_map[code_in*ENTRY_BITS +: ENTRY_BITS];
   assign invalid_in = (entry_in >= ENTRY_BITS'(NUM_SECTORS));

   assign rem_shift = {rem_ff, quot_ff[DIV_BITS-1]};
   assign rem_trial = rem_shift - {1'b0, dt_ff};
   assign fits      = !rem_trial[TIME_BITS];

   assign diff = $signed({1'b0, entry_ff}) - $signed({1'b0, sector_ff});

   always_comb begin
      if (diff > 4'sd3) begin
         ccw_in = 1'b1;
      end else if (diff < -4'sd3) begin
         ccw_in = 1'b0;
      end else begin
         ccw_in = (diff > 4'sd0) ? 1'b0 : 1'b1;
      end
   end

   // quotient above the positive range saturates, zero elapsed time included
   assign mag    = (quot_ff > DIV_BITS'(VEL_MAX)) ? VEL_MAX : quot_ff[VEL_BITS-2:0];
   assign vel_in = ccw_in ? (VEL_BITS'(0) - {1'b0, mag}) : {1'b0, mag};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff    <= code_in;
         entry_ff   <= entry_in[SECTOR_BITS-1:0];
         invalid_ff <= invalid_in;
         now_ff     <= req_time_us;
      end
      if (cmd.div_start) begin
         dt_ff   <= now_ff - last_ff;
         rem_ff  <= '0;
         quot_ff <= VEL_CONST;
      end else if (cmd.div_step) begin
         if (fits) begin
            rem_ff <= rem_trial[TIME_BITS-1:0];
         end else begin
            rem_ff <= rem_shift[TIME_BITS-1:0];
         end
         quot_ff <= {quot_ff[DIV_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= 1'b0;
         first_ff   <= 1'b0;
         sector_ff  <= '0;
         known_ff   <= 1'b0;
         ccw_ff     <= 1'b0;
         vel_ff     <= '0;
         last_ff    <= '0;
         stepped_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            step_ff    <= !invalid_in && known_ff &&
                          (entry_in[SECTOR_BITS-1:0] != sector_ff);
            first_ff   <= !invalid_in && !known_ff;
            stepped_ff <= 1'b0;
         end
         if (cmd.commit) begin
            if (first_ff) begin
               sector_ff <= entry_ff;
               known_ff  <= 1'b1;
            end
            if (step_ff) begin
               sector_ff  <= entry_ff;
               ccw_ff     <= ccw_in;
               vel_ff     <= vel_in;
               last_ff    <= now_ff;
               stepped_ff <= 1'b1;
            end
         end
      end
   end

   assign status.step = step_ff;

   assign rsp_sample_code  = code_ff;
   assign rsp_sector       = sector_ff;
   assign rsp_dir_ccw      = ccw_ff;
   assign rsp_velocity     = $signed(vel_ff);
   assign rsp_stepped      = stepped_ff;
   assign rsp_code_invalid = invalid_ff;

endmodule

// File: rtl/hall_sector_direction_velocity.sv
// ----------------------------------------------------------------------------
// hall_sector_direction_velocity
// decodes hall samples into rotor sector, direction and held velocity
// ----------------------------------------------------------------------------
// usage
// - input channel req_*: one word per hall sample, three line levels
//   (a is code bit 2, c is code bit 0) and a wrapping microsecond timestamp
// - result channel rsp_*: exactly one word per sample with the hall code,
//   stored sector, direction, held velocity (signed, 8 fraction bits),
//   a step flag and an invalid-code flag
// - apb port: one register, sector_map at byte address 0, eight nibbles;
//   a nibble of 6 or more marks that hall code invalid; write only while idle
// - flow: a sample that does not step is committed straight after its
//   evaluation; a step first runs the restoring divider for one quotient bit
//   per cycle (40 bits), then commits its result
// - one sample at a time: req_ready is high only while the sequencer is
//   idle, so a new sample waits until the previous result is taken
// - reset: sector, direction, velocity and last step time clear, sector
//   unknown, sector_map back to its default; the first valid sample after
//   reset only loads the sector
// - stall: the result stays on rsp_* until taken, and no new sample is
//   accepted before then
// ----------------------------------------------------------------------------
module hall_sector_direction_velocity
   import hsdv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_hall_a,
   input  logic                   req_hall_b,
   input  logic                   req_hall_c,
   input  logic [TIME_BITS-1:0]   req_time_us,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CODE_BITS-1:0]   rsp_sample_code,
   output logic [SECTOR_BITS-1:0] rsp_sector,
   output logic                   rsp_dir_ccw,
   output logic signed [VEL_BITS-1:0] rsp_velocity,
   output logic                   rsp_stepped,
   output logic                   rsp_code_invalid,
   // configuration
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_BITS-1:0]   paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   cmd_type     cmd;
   status_type  status;
   logic [31:0] sector_map_ff;
   logic        reg_sel;

   // word address picks the register, byte offset ignored
   assign reg_sel = (paddr[ADDR_BITS-1] == REG_SECTOR_MAP);
   assign pready  = 1'b1;

   // sector table register
   always_ff @(posedge clock) begin
      if (reset) begin
         sector_map_ff <= SECTOR_MAP_RESET;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         sector_map_ff <= pwdata;
      end
   end

   // read back, unmapped word reads zero
   assign prdata = reg_sel ? sector_map_ff : 32'd0;

   // sequencer
   hsdv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // lookup, rotor state and divider
   hsdv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sector_map       (sector_map_ff),
      .req_hall_a       (req_hall_a),
      .req_hall_b       (req_hall_b),
      .req_hall_c       (req_hall_c),
      .req_time_us      (req_time_us),
      .rsp_sample_code  (rsp_sample_code),
      .rsp_sector       (rsp_sector),
      .rsp_dir_ccw      (rsp_dir_ccw),
      .rsp_velocity     (rsp_velocity),
      .rsp_stepped      (rsp_stepped),
      .rsp_code_invalid (rsp_code_invalid)
   );

endmodule

// File: tb/sv/tb_hall_sector_direction_velocity.sv
// ----------------------------------------------------------------------------
// tb_hall_sector_direction_velocity
// self-checking bench for the hall sector / direction / velocity decoder
// ----------------------------------------------------------------------------
// a directed list of hall samples walks the invalid codes, the first sample
// that only loads the sector, both wrap directions, zero and full-range
// elapsed times; then random motor-like sample streams run under several
// sector maps and three handshake idling patterns. every result word is
// checked field by field against typed values or an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_hall_sector_direction_velocity
   import hsdv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 60;
   localparam int MAX_REPORTS   = 40;
   localparam int NUM_PHASES    = 8;
   localparam int DIRECTED_ROWS = 24;

   // sector map after reset
   localparam logic [31:0] DEFAULT_MAP = 32'hF354120F;
   localparam logic [ADDR_BITS-1:0] SECTOR_MAP_ADDR = {REG_SECTOR_MAP, 2'b00};

   // pi/3 * 1e6 rad/s in q.16, rounded half up to the output fraction bits
   localparam logic [63:0] K_PI3_Q16 = 64'd68629138715;
   localparam int          K_SHIFT   = 16 - VEL_FRAC_BITS;
   localparam logic [63:0] VEL_SCALE = (K_SHIFT <= 0) ? K_PI3_Q16 :
                                       (K_PI3_Q16 + (64'd1 << (K_SHIFT - 1))) >> K_SHIFT;
   localparam logic [63:0] VEL_LIMIT = 64'd2147483647;

   localparam bit TYPED = 1'b1;
   localparam bit MODEL = 1'b0;

   typedef struct packed {
      logic [CODE_BITS-1:0]   sample_code;
      logic [SECTOR_BITS-1:0] sector;
      logic                   dir_ccw;
      logic [VEL_BITS-1:0]    velocity;
      logic                   stepped;
      logic                   code_invalid;
   } hall_result_type;

   // one directed sample; the result fields only count when typed is set
   typedef struct packed {
      logic [CODE_BITS-1:0]   code;
      logic [TIME_BITS-1:0]   stamp;
      logic                   typed;
      logic [SECTOR_BITS-1:0] sector;
      logic                   dir_ccw;
      logic [VEL_BITS-1:0]    velocity;
      logic                   stepped;
      logic                   code_invalid;
   } directed_row_type;

   // default map: code 1->0, 3->1, 2->2, 6->3, 4->4, 5->5, codes 0 and 7 invalid
   localparam directed_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // invalid codes straight after reset, nothing known yet
      {3'd0, 32'h00000000, TYPED, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b1},
      {3'd7, 32'hFFFFFFFF, TYPED, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b1},
      // first valid sample only loads the sector, then an unchanged one
      {3'd1, 32'h00000064, TYPED, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd1, 32'h000000C8, TYPED, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      // zero elapsed time saturates, sign follows the direction
      {3'd3, 32'h00000000, TYPED, 3'd1, 1'b0, 32'sd2147483647, 1'b1, 1'b0},
      {3'd2, 32'h00000000, TYPED, 3'd2, 1'b0, 32'sd2147483647, 1'b1, 1'b0},
      {3'd3, 32'h00000000, TYPED, 3'd1, 1'b1, -32'sd2147483647, 1'b1, 1'b0},
      // largest elapsed time gives a zero magnitude
      {3'd1, 32'hFFFFFFFF, TYPED, 3'd0, 1'b1, 32'sd0, 1'b1, 1'b0},
      // timestamp wraps, sector 0 -> 5 reads as one step back
      {3'd5, 32'h00000010, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      // 5 -> 0 reads as one step forward, then a full forward turn
      {3'd1, 32'h00001000, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd3, 32'h000013E8, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd2, 32'h000017D0, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd6, 32'h00001BB8, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd4, 32'h00001FA0, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd5, 32'h00002388, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd1, 32'h00002770, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      // invalid codes once a sector is known leave everything alone
      {3'd0, 32'h12345678, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd7, 32'h80000000, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd1, 32'h00002771, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      // differences of +4, -3, +2, -3, +3 around the wrap limits
      {3'd4, 32'h00002772, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd3, 32'h00002773, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd6, 32'h7FFFFFFF, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd1, 32'hFFFFFFFE, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0},
      {3'd6, 32'hFFFFFFFF, MODEL, 3'd0, 1'b0, 32'sd0, 1'b0, 1'b0}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_hall_a;
   logic                         req_hall_b;
   logic                         req_hall_c;
   logic [TIME_BITS-1:0]         req_time_us;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [CODE_BITS-1:0]         rsp_sample_code;
   logic [SECTOR_BITS-1:0]       rsp_sector;
   logic                         rsp_dir_ccw;
   logic signed [VEL_BITS-1:0]   rsp_velocity;
   logic                         rsp_stepped;
   logic                         rsp_code_invalid;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [ADDR_BITS-1:0]         paddr;
   logic [31:0]                  pwdata;
   logic [31:0]                  prdata;
   logic                         pready;

   // decoder model state
   logic [31:0]            model_map;
   logic [SECTOR_BITS-1:0] model_sector;
   logic                   model_known;
   logic                   model_ccw;
   logic [VEL_BITS-1:0]    model_velocity;
   logic [TIME_BITS-1:0]   model_last_step;

   hall_result_type expected_decodes [$];

   // stimulus state and handshake knobs
   logic [TIME_BITS-1:0] stim_stamp;
   logic                 stim_ccw;
   int                   req_idle_pct;
   int                   rsp_idle_pct;
   bit                   hold_burst;

   // run statistics
   int cycle_count;
   int mismatch_count;
   int results_seen;
   int steps_seen;
   int invalid_seen;
   int samples_sent;

   hall_sector_direction_velocity dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_hall_a       (req_hall_a),
      .req_hall_b       (req_hall_b),
      .req_hall_c       (req_hall_c),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_code  (rsp_sample_code),
      .rsp_sector       (rsp_sector),
      .rsp_dir_ccw      (rsp_dir_ccw),
      .rsp_velocity     (rsp_velocity),
      .rsp_stepped      (rsp_stepped),
      .rsp_code_invalid (rsp_code_invalid),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_decodes.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s is %0h, expected %0h",
                                   results_seen, name, got, want));
      end
   endtask

   // decode one accepted sample and advance the model state
   function automatic hall_result_type decode_sample(input logic [CODE_BITS-1:0] code,
                                                     input logic [TIME_BITS-1:0] stamp);
      hall_result_type      r;
      logic [3:0]           entry;
      logic [TIME_BITS-1:0] elapsed;
      logic [63:0]          mag;
      int                   diff;
      entry          = model_map[4*code +: 4];
      r.sample_code  = code;
      r.stepped      = 1'b0;
      r.code_invalid = (entry >= 4'd6);
      if (entry < 4'd6) begin
         if (!model_known) begin
            // first valid sample only sets the sector
            model_sector = entry[SECTOR_BITS-1:0];
            model_known  = 1'b1;
         end else if (entry[SECTOR_BITS-1:0] != model_sector) begin
            diff = int'(entry) - int'(model_sector);
            // differences beyond +-3 go the short way round
            if (diff > 3) begin
               model_ccw = 1'b1;
            end else if (diff < -3) begin
               model_ccw = 1'b0;
            end else begin
               model_ccw = (diff < 0);
            end
            elapsed = stamp - model_last_step;
            mag     = (elapsed == '0) ? VEL_LIMIT : VEL_SCALE / elapsed;
            if (mag > VEL_LIMIT) begin
               mag = VEL_LIMIT;
            end
            model_velocity  = model_ccw ? -mag[VEL_BITS-1:0] : mag[VEL_BITS-1:0];
            model_sector    = entry[SECTOR_BITS-1:0];
            model_last_step = stamp;
            r.stepped       = 1'b1;
         end
      end
      r.sector   = model_sector;
      r.dir_ccw  = model_ccw;
      r.velocity = model_velocity;
      return r;
   endfunction

   // offer one sample, starting and ending on a falling edge
   task automatic drive_sample(input logic [CODE_BITS-1:0] code,
                               input logic [TIME_BITS-1:0] stamp,
                               input logic typed, input hall_result_type typed_result);
      hall_result_type predicted;
      int              gap;
      gap = 0;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         // mostly short gaps, now and then one long enough to span a divide
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_hall_a  <= code[2];
      req_hall_b  <= code[1];
      req_hall_c  <= code[0];
      req_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted on this edge
      predicted = decode_sample(code, stamp);
      expected_decodes.push_back(typed ? typed_result : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic write_sector_map(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SECTOR_MAP_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      model_map = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (expected_decodes.size() != 0) @(negedge clock);
   endtask

   // six distinct codes get sectors 0..5, the other two get invalid entries
   function automatic logic [31:0] random_sector_map();
      logic [31:0] m;
      int          order [8];
      int          j;
      int          tmp;
      for (int k = 0; k < 8; k++) begin
         order[k]    = k;
         m[4*k +: 4] = 4'($urandom_range(6, 15));
      end
      for (int k = 7; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (int k = 0; k < 6; k++) begin
         m[4*order[k] +: 4] = 4'(k);
      end
      return m;
   endfunction

   // motor-like stream: mostly the neighbor sector in the running direction,
   // some repeats of the current code and some arbitrary codes
   task automatic pick_sample(output logic [CODE_BITS-1:0] code,
                              output logic [TIME_BITS-1:0] stamp);
      logic [CODE_BITS-1:0]   hits [$];
      logic [SECTOR_BITS-1:0] want;
      int                     roll;
      int                     pace;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8) begin
         stim_ccw = ~stim_ccw;
      end
      if (stim_ccw) begin
         want = (model_sector == 0) ? 3'd5 : model_sector - 3'd1;
      end else begin
         want = (model_sector == 5) ? 3'd0 : model_sector + 3'd1;
      end
      if (roll >= 70) begin
         want = model_sector;
      end
      for (int k = 0; k < 8; k++) begin
         if (model_map[4*k +: 4] == {1'b0, want}) begin
            hits.push_back(CODE_BITS'(k));
         end
      end
      if (roll >= 80 || hits.size() == 0) begin
         code = CODE_BITS'($urandom_range(0, 7));
      end else begin
         code = hits[$urandom_range(0, hits.size() - 1)];
      end
      pace = $urandom_range(0, 99);
      if (pace < 8) begin
         stim_stamp = stim_stamp;          // same timestamp, zero elapsed
      end else if (pace < 16) begin
         stim_stamp = $urandom;            // jump anywhere, wraps included
      end else if (pace < 26) begin
         stim_stamp = stim_stamp + $urandom_range(1, 3);
      end else begin
         stim_stamp = stim_stamp + $urandom_range(4, 20000);
      end
      stamp = stim_stamp;
   endtask

   // result side: random or long held-off ready, changed on the falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_burst) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_burst = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin : result_check
      hall_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_decodes.pop_front();
            check_field("sample_code", 32'(rsp_sample_code), 32'(want.sample_code));
            check_field("sector", 32'(rsp_sector), 32'(want.sector));
            check_field("dir_ccw", 32'(rsp_dir_ccw), 32'(want.dir_ccw));
            check_field("velocity", rsp_velocity, want.velocity);
            check_field("stepped", 32'(rsp_stepped), 32'(want.stepped));
            check_field("code_invalid", 32'(rsp_code_invalid), 32'(want.code_invalid));
         end
         results_seen++;
         if (rsp_stepped === 1'b1) begin
            steps_seen++;
         end
         if (rsp_code_invalid === 1'b1) begin
            invalid_seen++;
         end
      end
   end

   // main sequence
   initial begin
      hall_result_type      row_result;
      logic [CODE_BITS-1:0] code;
      logic [TIME_BITS-1:0] stamp;
      logic [31:0]          phase_map;
      int                   phase_items;

      // every input known from time zero
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_hall_a   = 1'b0;
      req_hall_b   = 1'b0;
      req_hall_c   = 1'b0;
      req_time_us  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      hold_burst   = 1'b0;
      stim_stamp   = '0;
      stim_ccw     = 1'b0;
      cycle_count    = 0;
      mismatch_count = 0;
      results_seen   = 0;
      steps_seen     = 0;
      invalid_seen   = 0;
      samples_sent   = 0;

      // model state after reset
      model_map       = DEFAULT_MAP;
      model_sector    = '0;
      model_known     = 1'b0;
      model_ccw       = 1'b0;
      model_velocity  = '0;
      model_last_step = '0;

      // sender idles a little, receiver a lot
      req_idle_pct = 14;
      rsp_idle_pct = 71;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed list on the reset map
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row_result.sample_code  = DIRECTED_PLAN[i].code;
         row_result.sector       = DIRECTED_PLAN[i].sector;
         row_result.dir_ccw      = DIRECTED_PLAN[i].dir_ccw;
         row_result.velocity     = DIRECTED_PLAN[i].velocity;
         row_result.stepped      = DIRECTED_PLAN[i].stepped;
         row_result.code_invalid = DIRECTED_PLAN[i].code_invalid;
         drive_sample(DIRECTED_PLAN[i].code, DIRECTED_PLAN[i].stamp,
                      DIRECTED_PLAN[i].typed, row_result);
      end
      stim_stamp = DIRECTED_PLAN[DIRECTED_ROWS-1].stamp;

      // random streams, one sector map per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               phase_map   = DEFAULT_MAP;
               phase_items = 300;
            end
            1: begin
               phase_map   = 32'h00000000;   // every code is sector 0
               phase_items = 60;
            end
            3: begin
               phase_map   = 32'hFFFFFFFF;   // every code invalid
               phase_items = 60;
            end
            5: begin
               phase_map   = 32'h55555555;   // every code is sector 5
               phase_items = 60;
            end
            2, 4: begin
               phase_map   = random_sector_map();
               phase_items = 250;
            end
            default: begin
               phase_map   = random_sector_map();
               phase_items = 360;
            end
         endcase
         if (p < 3) begin
            req_idle_pct = 14;
            rsp_idle_pct = 71;
         end else if (p < 6) begin
            req_idle_pct = 71;
            rsp_idle_pct = 14;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         // the map only changes while the block is idle
         req_valid <= 1'b0;
         @(negedge clock);
         wait_for_drain();
         write_sector_map(phase_map);

         for (int i = 0; i < phase_items; i++) begin
            if (p == 6 && i == 100) begin
               // receiver holds off while samples keep coming
               hold_burst = 1'b1;
            end
            if (p == 6 && i == 200) begin
               // sender stops until every result is back
               req_valid <= 1'b0;
               @(negedge clock);
               wait_for_drain();
            end
            pick_sample(code, stamp);
            drive_sample(code, stamp, MODEL, row_result);
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      wait_for_drain();
      // catch any stray word after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d samples (%0d directed) under %0d sector maps",
               samples_sent, DIRECTED_ROWS, NUM_PHASES + 1);
      $display("checked %0d result words: %0d steps, %0d invalid codes, %0d mismatches",
               results_seen, steps_seen, invalid_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
